// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

	localparam int FACTOR_W   = 2;
	localparam int BUCKET_W   = 6;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 48;
	localparam int SKETCH_W   = 32;
	localparam int KREG_W     = 7;
	localparam int PREG_W     = 3;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_MAX_BUCKETS   = 64;
	localparam int DEF_MAX_FACTORS   = 4;
	localparam int DEF_FRACTION_BITS = 13;

	localparam logic [KREG_W-1:0] K_RESET = 7'd64;
	localparam logic [PREG_W-1:0] P_RESET = 3'd2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BUCKET_COUNT = 8'd0,
		REG_FACTOR_COUNT = 8'd1
	} reg_index_t;

	typedef struct packed {
		logic clear;
		logic start;
	} mac_ctrl_t;

endpackage

// ===== rtl/tsc_if.sv =====
interface tsc_in_if;
	logic                           valid;
	logic                           ready;
	logic [tsc_pkg::FACTOR_W-1:0]   factor_index;
	logic [tsc_pkg::BUCKET_W-1:0]   bucket;
	logic                           negate;
	logic signed [tsc_pkg::SAMPLE_W-1:0] sample;
	logic                           column_done;

	modport source(output valid, factor_index, bucket, negate, sample, column_done,
		input ready);
	modport sink(input valid, factor_index, bucket, negate, sample, column_done,
		output ready);
endinterface

interface tsc_out_if;
	logic                                valid;
	logic                                ready;
	logic [tsc_pkg::BUCKET_W-1:0]        coefficient_index;
	logic signed [tsc_pkg::COEF_W-1:0]   coefficient;
	logic                                final_coefficient;

	modport source(output valid, coefficient_index, coefficient, final_coefficient,
		input ready);
	modport sink(input valid, coefficient_index, coefficient, final_coefficient,
		output ready);
endinterface

interface tsc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tsc_pkg::CFG_ADDR_W-1:0]   index;
	logic [tsc_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/tsc_mac.sv =====
module tsc_mac #(
	parameter int FRACTION_BITS = tsc_pkg::DEF_FRACTION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsc_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [tsc_pkg::COEF_W-1:0]   a,
	input  logic signed [tsc_pkg::SKETCH_W-1:0] b,
	output logic                                done,
	output logic signed [tsc_pkg::COEF_W-1:0]   acc
);
	import tsc_pkg::*;

	localparam int FULL_W = COEF_W + SKETCH_W;
	localparam logic signed [COEF_W+1:0] SUM_MAX = $signed({3'b000, {(COEF_W-1){1'b1}}});
	localparam logic signed [COEF_W+1:0] SUM_MIN = $signed({3'b111, {(COEF_W-1){1'b0}}});

	typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_ACC} mstate_t;

	mstate_t                    st_q;
	logic [COEF_W-1:0]          ma_q;
	logic [SKETCH_W-1:0]        mb_q;
	logic                       neg_q;
	logic [COEF_W+15:0]         plo_q;
	logic [COEF_W+15:0]         phi_q;
	logic [FULL_W-1:0]          full_q;
	logic signed [COEF_W-1:0]   acc_q;
	logic                       done_q;

	logic [15:0]                half;
	logic [COEF_W+15:0]         prod;
	logic [FULL_W-1:0]          shifted;
	logic [FULL_W-1:0]          limit;
	logic [COEF_W:0]            mag;
	logic signed [COEF_W+1:0]   term;
	logic signed [COEF_W+1:0]   sum;
	logic signed [COEF_W-1:0]   sum_sat;

	// One 48x16 multiplier serves both halves of the 32-bit operand.
	assign half = (st_q == M_LO) ? mb_q[15:0] : mb_q[31:16];
	assign prod = (COEF_W+16)'(ma_q) * (COEF_W+16)'(half);

	always_comb begin
		shifted = full_q >> FRACTION_BITS;
		limit   = neg_q ? (FULL_W'(1) << (COEF_W-1)) : ((FULL_W'(1) << (COEF_W-1)) - FULL_W'(1));
		mag     = (shifted > limit) ? (COEF_W+1)'(limit) : (COEF_W+1)'(shifted);
		term    = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sum     = (COEF_W+2)'(acc_q) + term;
		if (sum > SUM_MAX)
			sum_sat = {1'b0, {(COEF_W-1){1'b1}}};
		else if (sum < SUM_MIN)
			sum_sat = {1'b1, {(COEF_W-1){1'b0}}};
		else
			sum_sat = COEF_W'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (ctrl.start) st_q <= M_LO;
				end
				M_LO:  st_q <= M_HI;
				M_HI:  st_q <= M_SUM;
				M_SUM: st_q <= M_ACC;
				M_ACC: begin
					st_q   <= M_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) acc_q <= '0;
		else if (st_q == M_ACC) acc_q <= sum_sat;
		if (st_q == M_IDLE && ctrl.start) begin
			ma_q  <= a[COEF_W-1] ? COEF_W'(0) - COEF_W'(a) : COEF_W'(a);
			mb_q  <= b[SKETCH_W-1] ? SKETCH_W'(0) - SKETCH_W'(b) : SKETCH_W'(b);
			neg_q <= a[COEF_W-1] ^ b[SKETCH_W-1];
		end
		if (st_q == M_LO) plo_q <= prod;
		if (st_q == M_HI) phi_q <= prod;
		if (st_q == M_SUM)
			full_q <= {phi_q, 16'd0} + FULL_W'(plo_q)
				+ (neg_q ? FULL_W'((FULL_W'(1) << FRACTION_BITS) - FULL_W'(1)) : FULL_W'(0));
	end

	assign done = done_q;
	assign acc  = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> st_q == M_IDLE) else $error("mac started while busy");
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> ##5 done_q) else $error("mac result late");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear && st_q != M_ACC |=> acc_q == '0) else $error("accumulator not cleared");

endmodule

// ===== rtl/tensor_sketch_column_unit.sv =====
// Tensor sketch of one column set. Each element costs a read and a write of the
// sketch RAM. The element flagged column_done starts a run: a copy of factor 0,
// then a pass for each further factor, in which every product term goes through
// the single shared multiply-round-accumulate unit, then a read, a load and a hold
// per coefficient delivered (plus any output stall), then a clearing pass over
// the MAX_FACTORS*MAX_BUCKETS entries of the sketch RAM. The same clearing pass
// runs after reset. Elements are not accepted during any of this;
// configuration writes are always taken and should only be made while idle.
module tensor_sketch_column_unit #(
	parameter int MAX_BUCKETS   = tsc_pkg::DEF_MAX_BUCKETS,
	parameter int MAX_FACTORS   = tsc_pkg::DEF_MAX_FACTORS,
	parameter int FRACTION_BITS = tsc_pkg::DEF_FRACTION_BITS
) (
	input logic        clk,
	input logic        arst_n,
	tsc_in_if.sink     samples,
	tsc_out_if.source  coeffs,
	tsc_cfg_if.sink    cfg
);
	import tsc_pkg::*;

	localparam int DEPTH = MAX_FACTORS * MAX_BUCKETS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_BUCKETS);
	localparam logic signed [SKETCH_W+1:0] UPD_MAX = $signed({3'b000, {(SKETCH_W-1){1'b1}}});
	localparam logic signed [SKETCH_W+1:0] UPD_MIN = $signed({3'b111, {(SKETCH_W-1){1'b0}}});

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_ACC, S_CP_RD, S_CP_WR, S_CV_RD, S_CV_WT, S_CV_MAC,
		S_CV_WR, S_EM_RD, S_EM_LD, S_EM_HOLD
	} state_t;

	state_t                      st_q;
	logic [KREG_W-1:0]           k_q;
	logic [PREG_W-1:0]           p_q;
	logic [AW-1:0]               clr_q;
	logic [KREG_W-1:0]           i_q;
	logic [KREG_W-1:0]           j_q;
	logic [PREG_W-1:0]           g_q;
	logic                        cur_q;
	logic                        acc_ok_q;
	logic                        done_flag_q;
	logic                        negate_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic [AW-1:0]               item_addr_q;

	logic signed [SKETCH_W-1:0]  sk_mem [DEPTH];
	logic signed [SKETCH_W-1:0]  sk_rd_q;
	logic signed [COEF_W-1:0]    pr_mem [2*MAX_BUCKETS];
	logic signed [COEF_W-1:0]    pr_rd_q;

	logic                        out_valid_q;
	logic [BUCKET_W-1:0]         out_index_q;
	logic signed [COEF_W-1:0]    out_coef_q;
	logic                        out_final_q;

	logic [AW-1:0]               item_addr;
	logic                        item_ok;
	logic [7:0]                  t_idx;
	logic [AW-1:0]               sk_raddr;
	logic                        sk_we;
	logic [AW-1:0]               sk_waddr;
	logic signed [SKETCH_W-1:0]  sk_wdata;
	logic [IW:0]                 pr_raddr;
	logic                        pr_we;
	logic [IW:0]                 pr_waddr;
	logic signed [COEF_W-1:0]    pr_wdata;
	logic signed [SKETCH_W+1:0]  upd;
	logic                        accept;
	logic                        last_i;
	logic                        last_j;
	logic                        last_g;
	mac_ctrl_t                   mac_ctrl;
	logic                        mac_done;
	logic signed [COEF_W-1:0]    mac_acc;
	logic [KREG_W-1:0]           k_new;
	logic [PREG_W-1:0]           p_new;

	assign accept   = samples.valid && samples.ready;
	assign samples.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign last_i   = (i_q == k_q - KREG_W'(1));
	assign last_j   = (j_q == k_q - KREG_W'(1));
	assign last_g   = (PREG_W'(g_q + PREG_W'(1)) >= p_q);

	assign item_addr = AW'(samples.factor_index) * AW'(MAX_BUCKETS) + AW'(samples.bucket);
	assign item_ok   = (PREG_W'(samples.factor_index) < p_q)
		&& (KREG_W'(samples.bucket) < k_q);
	assign t_idx = (i_q >= j_q) ? 8'(i_q) - 8'(j_q) : 8'(i_q) + 8'(k_q) - 8'(j_q);

	always_comb begin
		upd = (SKETCH_W+2)'(sk_rd_q)
			+ (negate_q ? -(SKETCH_W+2)'(sample_q) : (SKETCH_W+2)'(sample_q));
		sk_raddr = item_addr;
		sk_we    = 1'b0;
		sk_waddr = clr_q;
		sk_wdata = '0;
		pr_raddr = {cur_q, IW'(j_q)};
		pr_we    = 1'b0;
		pr_waddr = {~cur_q, IW'(i_q)};
		pr_wdata = mac_acc;
		mac_ctrl = '0;
		case (st_q)
			S_CLR: sk_we = 1'b1;
			S_ACC: begin
				sk_we    = acc_ok_q;
				sk_waddr = item_addr_q;
				if (upd > UPD_MAX)
					sk_wdata = {1'b0, {(SKETCH_W-1){1'b1}}};
				else if (upd < UPD_MIN)
					sk_wdata = {1'b1, {(SKETCH_W-1){1'b0}}};
				else
					sk_wdata = SKETCH_W'(upd);
			end
			S_CP_RD: sk_raddr = AW'(i_q);
			S_CP_WR: begin
				pr_we    = 1'b1;
				pr_waddr = {1'b0, IW'(i_q)};
				pr_wdata = COEF_W'(sk_rd_q);
			end
			S_CV_RD: begin
				sk_raddr       = AW'(g_q) * AW'(MAX_BUCKETS) + AW'(t_idx);
				mac_ctrl.clear = (j_q == '0);
			end
			S_CV_WT: mac_ctrl.start = 1'b1;
			S_CV_WR: pr_we = 1'b1;
			S_EM_RD: pr_raddr = {cur_q, IW'(i_q)};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sk_we) sk_mem[sk_waddr] <= sk_wdata;
		sk_rd_q <= sk_mem[sk_raddr];
		if (pr_we) pr_mem[pr_waddr] <= pr_wdata;
		pr_rd_q <= pr_mem[pr_raddr];
	end

	tsc_mac #(.FRACTION_BITS(FRACTION_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (pr_rd_q),
		.b      (sk_rd_q),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	always_comb begin
		k_new = KREG_W'(cfg.data);
		if (k_new == '0) k_new = KREG_W'(1);
		else if (32'(k_new) > MAX_BUCKETS) k_new = KREG_W'(MAX_BUCKETS);
		p_new = PREG_W'(cfg.data);
		if (p_new == '0) p_new = PREG_W'(1);
		else if (32'(p_new) > MAX_FACTORS) p_new = PREG_W'(MAX_FACTORS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			k_q         <= (32'(K_RESET) > MAX_BUCKETS) ? KREG_W'(MAX_BUCKETS) : K_RESET;
			p_q         <= (32'(P_RESET) > MAX_FACTORS) ? PREG_W'(MAX_FACTORS) : P_RESET;
			i_q         <= '0;
			j_q         <= '0;
			g_q         <= '0;
			cur_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_BUCKET_COUNT) k_q <= k_new;
				else if (cfg.index == REG_FACTOR_COUNT) p_q <= p_new;
			end
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) st_q <= S_ACC;
				end
				S_ACC: begin
					i_q <= '0;
					if (done_flag_q) st_q <= S_CP_RD;
					else st_q <= S_IDLE;
				end
				S_CP_RD: st_q <= S_CP_WR;
				S_CP_WR: begin
					if (last_i) begin
						i_q   <= '0;
						j_q   <= '0;
						g_q   <= PREG_W'(1);
						cur_q <= 1'b0;
						st_q  <= (p_q == PREG_W'(1)) ? S_EM_RD : S_CV_RD;
					end else begin
						i_q  <= i_q + KREG_W'(1);
						st_q <= S_CP_RD;
					end
				end
				S_CV_RD: st_q <= S_CV_WT;
				S_CV_WT: st_q <= S_CV_MAC;
				S_CV_MAC: begin
					if (mac_done) begin
						if (last_j) begin
							st_q <= S_CV_WR;
						end else begin
							j_q  <= j_q + KREG_W'(1);
							st_q <= S_CV_RD;
						end
					end
				end
				S_CV_WR: begin
					j_q <= '0;
					if (last_i) begin
						i_q   <= '0;
						cur_q <= ~cur_q;
						g_q   <= g_q + PREG_W'(1);
						st_q  <= last_g ? S_EM_RD : S_CV_RD;
					end else begin
						i_q  <= i_q + KREG_W'(1);
						st_q <= S_CV_RD;
					end
				end
				S_EM_RD: st_q <= S_EM_LD;
				S_EM_LD: begin
					out_valid_q <= 1'b1;
					st_q        <= S_EM_HOLD;
				end
				S_EM_HOLD: begin
					if (coeffs.ready) begin
						out_valid_q <= 1'b0;
						if (last_i) begin
							clr_q <= '0;
							st_q  <= S_CLR;
						end else begin
							i_q  <= i_q + KREG_W'(1);
							st_q <= S_EM_RD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_ok_q    <= item_ok;
			done_flag_q <= samples.column_done;
			negate_q    <= samples.negate;
			sample_q    <= samples.sample;
			item_addr_q <= item_addr;
		end
		if (st_q == S_EM_LD) begin
			out_index_q <= BUCKET_W'(i_q);
			out_coef_q  <= pr_rd_q;
			out_final_q <= last_i;
		end
	end

	assign coeffs.valid             = out_valid_q;
	assign coeffs.coefficient_index = out_index_q;
	assign coeffs.coefficient       = out_coef_q;
	assign coeffs.final_coefficient = out_final_q;

	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		!(samples.ready && coeffs.valid)) else $error("input open during emission");
	a_final_index: assert property (@(posedge clk) disable iff (!arst_n)
		coeffs.valid && coeffs.final_coefficient |->
			coeffs.coefficient_index == BUCKET_W'(k_q - KREG_W'(1)))
		else $error("final flag on wrong coefficient");
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		coeffs.valid && coeffs.ready && coeffs.final_coefficient |=> st_q == S_CLR)
		else $error("sketch store not cleared after run");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	import tsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC       = DEF_FRACTION_BITS;
	localparam int     NBUCKETS   = DEF_MAX_BUCKETS;
	localparam int     NFACTORS   = DEF_MAX_FACTORS;
	localparam longint COEF_MAX   = (longint'(1) <<< 47) - 1;
	localparam longint COEF_MIN   = -COEF_MAX - 1;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 8'd5;
	localparam int     IDLE_LIMIT = 300000;
	localparam int     DRAIN_CYCLES = 400;
	localparam int     SAT_PER_FACTOR = 92;
	localparam int     ITEM_TARGET = 440;

	typedef struct {
		logic [BUCKET_W-1:0]      idx;
		logic signed [COEF_W-1:0] val;
		bit                       fin;
	} coef_t;

	logic clk;
	logic arst_n;

	tsc_in_if  samples_ch();
	tsc_out_if coeffs_ch();
	tsc_cfg_if cfg_ch();

	tensor_sketch_column_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.coeffs  (coeffs_ch),
		.cfg     (cfg_ch)
	);

	// Predictor state: the factor sketches and the registers in force.
	int          sketch[NFACTORS][NBUCKETS];
	int unsigned k_now;
	int unsigned p_now;
	coef_t       pending_coefs[$];

	int  errors;
	int  elements_sent;
	int  columns_done;
	int  coefs_checked;
	int  idle_cycles;
	bit  quiet;
	int  out_hold;
	bit  out_state;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic longint clamp48(input logic signed [79:0] v);
		if (v > COEF_MAX) return COEF_MAX;
		if (v < COEF_MIN) return COEF_MIN;
		return longint'(v);
	endfunction

	// Exact product, floored by the fraction shift, then held to 48 bits.
	function automatic longint mul_q13(input longint a, input int b);
		logic signed [79:0] wa;
		logic signed [79:0] wb;
		logic signed [79:0] pr;
		wa = a;
		wb = b;
		pr = (wa * wb) >>> FRAC;
		return clamp48(pr);
	endfunction

	function automatic void convolve_and_emit();
		longint run[NBUCKETS];
		longint nxt[NBUCKETS];
		longint acc;
		int unsigned t;
		coef_t c;
		for (int i = 0; i < k_now; i++) run[i] = sketch[0][i];
		for (int g = 1; g < p_now; g++) begin
			for (int i = 0; i < k_now; i++) begin
				acc = 0;
				for (int j = 0; j < k_now; j++) begin
					t = (i + k_now - j) % k_now;
					acc = clamp48(acc + mul_q13(run[j], sketch[g][t]));
				end
				nxt[i] = acc;
			end
			for (int i = 0; i < k_now; i++) run[i] = nxt[i];
		end
		for (int i = 0; i < k_now; i++) begin
			c.idx = BUCKET_W'(i);
			c.val = run[i][COEF_W-1:0];
			c.fin = (i + 1 == k_now);
			pending_coefs = {pending_coefs, c};
		end
		for (int f = 0; f < NFACTORS; f++)
			for (int b = 0; b < NBUCKETS; b++) sketch[f][b] = 0;
		columns_done++;
	endfunction

	function automatic void accumulate(input logic [FACTOR_W-1:0] f, input logic [BUCKET_W-1:0] b,
		input bit neg, input logic signed [SAMPLE_W-1:0] s, input bit done);
		longint v;
		if (f < p_now && b < k_now) begin
			v = longint'(sketch[f][b]) + (neg ? -longint'(s) : longint'(s));
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			sketch[f][b] = int'(v);
		end
		if (done) convolve_and_emit();
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_element(input logic [FACTOR_W-1:0] f, input logic [BUCKET_W-1:0] b,
		input bit neg, input logic signed [SAMPLE_W-1:0] s, input bit done);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.factor_index <= f;
		samples_ch.bucket       <= b;
		samples_ch.negate       <= neg;
		samples_ch.sample       <= s;
		samples_ch.column_done  <= done;
		@(posedge clk);
		while (!samples_ch.ready) @(posedge clk);
		elements_sent++;
		accumulate(f, b, neg, s, done);
	endtask

	task automatic stop_sending();
		samples_ch.valid <= 1'b0;
	endtask

	// Waits for every outstanding coefficient, then lets the clearing pass finish.
	task automatic wait_idle();
		stop_sending();
		@(posedge clk);
		while (pending_coefs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		logic [KREG_W-1:0] kv;
		logic [PREG_W-1:0] pv;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_BUCKET_COUNT) begin
			kv = KREG_W'(data);
			if (kv == '0) kv = KREG_W'(1);
			if (kv > KREG_W'(NBUCKETS)) kv = KREG_W'(NBUCKETS);
			k_now = kv;
		end else if (idx == REG_FACTOR_COUNT) begin
			pv = PREG_W'(data);
			if (pv == '0) pv = PREG_W'(1);
			if (pv > PREG_W'(NFACTORS)) pv = PREG_W'(NFACTORS);
			p_now = pv;
		end
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7FFF;
		if (r == 1) return 16'sh8000;
		return SAMPLE_W'($urandom());
	endfunction

	// Mostly in-range elements; a few land on an unused factor or bucket.
	task automatic random_column(input int n);
		logic [FACTOR_W-1:0] f;
		logic [BUCKET_W-1:0] b;
		for (int e = 0; e < n; e++) begin
			f = ($urandom_range(0, 9) == 0) ? FACTOR_W'($urandom_range(0, 3))
				: FACTOR_W'($urandom_range(0, p_now - 1));
			b = ($urandom_range(0, 9) == 0) ? BUCKET_W'($urandom_range(0, 63))
				: BUCKET_W'($urandom_range(0, k_now - 1));
			send_element(f, b, $urandom_range(0, 1), pick_sample(), e == n - 1);
		end
	endtask

	task automatic test_defaults();
		send_element(2'd0, 6'd0, 1'b0, 16'sh7FFF, 1'b0);
		send_element(2'd0, 6'd63, 1'b1, 16'sh8000, 1'b0);
		send_element(2'd1, 6'd0, 1'b1, 16'sh7FFF, 1'b0);
		send_element(2'd1, 6'd63, 1'b0, 16'sh8000, 1'b0);
		send_element(2'd1, 6'd21, 1'b0, 16'sh1555, 1'b0);
		send_element(2'd3, 6'd5, 1'b0, 16'sh7FFF, 1'b0);
		send_element(2'd2, 6'd42, 1'b1, 16'sh2AAA, 1'b1);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_BUCKET_COUNT, 8'd0);
		write_reg(REG_FACTOR_COUNT, 8'd0);
		send_element(2'd0, 6'd0, 1'b1, 16'sh1234, 1'b0);
		send_element(2'd0, 6'd1, 1'b0, 16'sh7FFF, 1'b1);
		wait_idle();
		write_reg(REG_BUCKET_COUNT, 8'hFF);
		write_reg(REG_FACTOR_COUNT, 8'd7);
		write_reg(REG_UNUSED, 8'd3);
		for (int f = 0; f < 4; f++)
			send_element(FACTOR_W'(f), BUCKET_W'(f * 21), f[0], pick_sample(), 1'b0);
		send_element(2'd3, 6'd63, 1'b1, 16'sh8000, 1'b1);
		wait_idle();
	endtask

	// A column whose element ends it while being out of range still emits.
	task automatic test_lone_done();
		write_reg(REG_BUCKET_COUNT, 8'd3);
		write_reg(REG_FACTOR_COUNT, 8'd2);
		send_element(2'd0, 6'd50, 1'b0, 16'sh4000, 1'b1);
		wait_idle();
		send_element(2'd1, 6'd2, 1'b0, 16'sh4000, 1'b0);
		send_element(2'd3, 6'd0, 1'b1, 16'sh4000, 1'b1);
		wait_idle();
	endtask

	// Large sketch entries with one negated factor drive the product chain
	// past the most negative 48-bit value.
	task automatic test_saturation();
		write_reg(REG_BUCKET_COUNT, 8'd1);
		write_reg(REG_FACTOR_COUNT, 8'd4);
		for (int e = 0; e < 4 * SAT_PER_FACTOR; e++)
			send_element(FACTOR_W'(e % 4), 6'd0, (e % 4 == 0), 16'sh7FFF,
				e == 4 * SAT_PER_FACTOR - 1);
		wait_idle();
	endtask

	task automatic test_random();
		int kv;
		while (elements_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) kv = $urandom_range(33, 64);
			else if ($urandom_range(0, 4) == 0) kv = $urandom_range(13, 32);
			else kv = $urandom_range(1, 12);
			write_reg(REG_BUCKET_COUNT, CFG_DATA_W'(kv));
			if (kv > 32) write_reg(REG_FACTOR_COUNT, CFG_DATA_W'($urandom_range(0, 2)));
			else write_reg(REG_FACTOR_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
			repeat ($urandom_range(1, 4)) begin
				quiet = ($urandom_range(0, 3) == 0);
				random_column($urandom_range(1, 25));
				// Sometimes hold off until the whole result has drained.
				if ($urandom_range(0, 3) == 0) wait_idle();
			end
			quiet = 1'b0;
			wait_idle();
		end
	endtask

	always @(posedge clk) begin
		coef_t want;
		if (coeffs_ch.valid && coeffs_ch.ready) begin
			if (pending_coefs.size() == 0) begin
				report($sformatf("unexpected coefficient index %0d", coeffs_ch.coefficient_index));
			end else begin
				want = pending_coefs.pop_front();
				coefs_checked++;
				if (coeffs_ch.coefficient_index !== want.idx)
					report($sformatf("index got %0d want %0d", coeffs_ch.coefficient_index, want.idx));
				if (coeffs_ch.coefficient !== want.val)
					report($sformatf("coefficient %0d got %0d want %0d", want.idx,
						coeffs_ch.coefficient, want.val));
				if (coeffs_ch.final_coefficient !== want.fin)
					report($sformatf("final flag at %0d got %b want %b", want.idx,
						coeffs_ch.final_coefficient, want.fin));
			end
		end
	end

	// Receiver stalls: runs of ready and not ready, mostly short.
	always @(posedge clk) begin
		int len;
		bit nxt_state;
		nxt_state = out_state;
		if (!arst_n) begin
			nxt_state = 1'b0;
		end else if (out_hold > 0) begin
			out_hold <= out_hold - 1;
		end else begin
			nxt_state = quiet ? 1'b1 : ($urandom_range(0, 99) < 65);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			out_hold <= len;
		end
		out_state <= nxt_state;
		coeffs_ch.ready <= nxt_state;
	end

	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (coeffs_ch.valid && coeffs_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.factor_index = '0;
		samples_ch.bucket = '0;
		samples_ch.negate = 1'b0;
		samples_ch.sample = '0;
		samples_ch.column_done = 1'b0;
		coeffs_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		out_hold = 0;
		out_state = 1'b0;
		idle_cycles = 0;
		quiet = 1'b0;
		errors = 0;
		elements_sent = 0;
		columns_done = 0;
		coefs_checked = 0;
		k_now = K_RESET;
		p_now = P_RESET;
		for (int f = 0; f < NFACTORS; f++)
			for (int b = 0; b < NBUCKETS; b++) sketch[f][b] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		test_defaults();
		test_register_extremes();
		test_lone_done();
		test_saturation();
		test_random();

		wait_idle();
		$display("covered %0d elements over %0d columns, %0d coefficients compared",
			elements_sent, columns_done, coefs_checked);
		$display("register extremes, out-of-range elements and 48-bit clipping included");
		if (errors == 0 && pending_coefs.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
